### design/text_console_cursor_scroll_defines.svh
// Assertion macros for the text console block.
`ifndef TEXT_CONSOLE_CURSOR_SCROLL_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_SCROLL_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, held off during reset.
`define TCCS_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("text console assertion failed");
// Next-cycle implication, held off during reset.
`define TCCS_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("text console assertion failed");
`else
`define TCCS_ASSERT_IMP(label, ante, cons)
`define TCCS_ASSERT_NXT(label, ante, cons)
`endif

`endif

### design/tccs_pkg.sv
// Shared constants, types and address helpers for the text console block.
package tccs_pkg;

   // Screen geometry
   localparam int COLUMNS    = 80;
   localparam int ROWS       = 25;
   localparam int TAB_SPACES = 4;
   localparam int CELLS      = ROWS * COLUMNS;

   // Field widths fixed by the interface
   localparam int COL_W  = 7;
   localparam int ROW_W  = 5;
   localparam int CHAR_W = 8;
   localparam int CELL_W = 16;
   localparam int COLOR_W = 4;
   localparam int ATTR_W = 2 * COLOR_W;
   localparam int ADDR_W = $clog2(CELLS);
   localparam int TAB_W  = $clog2(TAB_SPACES + 1);
   localparam int CSR_IDX_W = 1;

   // Request codes
   typedef logic [2:0] op_type;
   localparam op_type OP_PUT     = 3'd0;
   localparam op_type OP_SET_COL = 3'd1;
   localparam op_type OP_SET_ROW = 3'd2;
   localparam op_type OP_CLEAR   = 3'd3;
   localparam op_type OP_READ    = 3'd4;

   // Register indexes
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;
   localparam csr_idx_type CSR_BACKGROUND = 1'b0;
   localparam csr_idx_type CSR_FOREGROUND = 1'b1;

   // Character codes
   localparam logic [CHAR_W-1:0] CHAR_NULL    = 8'h00;
   localparam logic [CHAR_W-1:0] CHAR_TAB     = 8'h09;
   localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;

   localparam logic [ATTR_W-1:0]  RESET_ATTR = 8'h0F;
   localparam logic [COLOR_W-1:0] RESET_BG   = 4'h0;
   localparam logic [COLOR_W-1:0] RESET_FG   = 4'hF;

   // Controller to datapath
   typedef struct packed {
      logic accept;
      logic write_char;
      logic newline;
      logic set_col;
      logic set_row;
      logic clear_start;
      logic sweep_write;
      logic sweep_reset_attr;
      logic read_cell;
      logic load_rsp;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      op_type op;
      logic   char_zero;
      logic   char_newline;
      logic   scroll_hit;
      logic   more_after;
      logic   chars_left;
      logic   sweep_last;
      logic   rsp_busy;
   } status_type;

   // Logical row to physical row of the circular row store
   function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] r,
                                                 input logic [ROW_W-1:0] b);
      logic [ROW_W:0] s;
      s = {1'b0, r} + {1'b0, b};
      if (s >= (ROW_W+1)'(ROWS)) begin
         s = s - (ROW_W+1)'(ROWS);
      end
      return s[ROW_W-1:0];
   endfunction

   // Physical row and column to memory address
   function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] prow,
                                                   input logic [COL_W-1:0] col);
      return ADDR_W'(prow) * ADDR_W'(COLUMNS) + ADDR_W'(col);
   endfunction

endpackage

### design/tccs_ctrl.sv
// Sequencing state machine for the text console block.
module tccs_ctrl import tccs_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [6:0] {
      ST_INIT  = 7'b0000001,
      ST_IDLE  = 7'b0000010,
      ST_EXEC  = 7'b0000100,
      ST_FILL  = 7'b0001000,
      ST_CLEAR = 7'b0010000,
      ST_READ  = 7'b0100000,
      ST_DONE  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE);

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_INIT: begin
            // power-up blanking of the whole screen
            cmd.sweep_write      = 1'b1;
            cmd.sweep_reset_attr = 1'b1;
            if (status.sweep_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_EXEC;
            end
         end
         ST_EXEC: begin
            case (status.op)
               OP_PUT: begin
                  if (status.char_zero) begin
                     state_in = ST_DONE;
                  end else if (status.char_newline) begin
                     cmd.newline = 1'b1;
                     state_in    = status.scroll_hit ? ST_FILL : ST_DONE;
                  end else begin
                     cmd.write_char = 1'b1;
                     if (status.scroll_hit)      state_in = ST_FILL;
                     else if (status.more_after) state_in = ST_EXEC;
                     else                        state_in = ST_DONE;
                  end
               end
               OP_SET_COL: begin
                  cmd.set_col = 1'b1;
                  state_in    = ST_DONE;
               end
               OP_SET_ROW: begin
                  cmd.set_row = 1'b1;
                  state_in    = ST_DONE;
               end
               OP_CLEAR: begin
                  cmd.clear_start = 1'b1;
                  state_in        = ST_CLEAR;
               end
               OP_READ: begin
                  cmd.read_cell = 1'b1;
                  state_in      = ST_READ;
               end
               default: state_in = ST_DONE;
            endcase
         end
         ST_FILL: begin
            // blank the new bottom row, then finish any tab spaces
            cmd.sweep_write = 1'b1;
            if (status.sweep_last) state_in = status.chars_left ? ST_EXEC : ST_DONE;
         end
         ST_CLEAR: begin
            cmd.sweep_write = 1'b1;
            if (status.sweep_last) state_in = ST_DONE;
         end
         ST_READ: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!status.rsp_busy) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_INIT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### design/tccs_dp.sv
// Datapath of the text console block: cursor, screen store, registers, result word.
module tccs_dp import tccs_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output status_type          status,
   input  logic [2:0]          req_type,
   input  logic [CHAR_W-1:0]   req_char_code,
   input  logic [ROW_W-1:0]    req_row,
   input  logic [COL_W-1:0]    req_column,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [COL_W-1:0]    rsp_cursor_column,
   output logic [ROW_W-1:0]    rsp_cursor_row,
   output logic [CELL_W-1:0]   rsp_cell_value,
   output logic                rsp_scrolled,
   input  logic                csr_wr_en,
   input  csr_idx_type         csr_index,
   input  logic [COLOR_W-1:0]  csr_wdata
);

   // Control state
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  line_ff, line_in;
   logic [ROW_W-1:0]  base_ff, base_in;
   logic [ADDR_W-1:0] sweep_addr_ff, sweep_addr_in;
   logic [ADDR_W-1:0] sweep_cnt_ff, sweep_cnt_in;
   logic [TAB_W-1:0]  tab_left_ff, tab_left_in;
   logic              sc_ff, sc_in;
   logic [COLOR_W-1:0] bg_ff, fg_ff;
   logic              rsp_valid_ff, rsp_valid_in;

   // Payload registers
   op_type            op_ff;
   logic [CHAR_W-1:0] char_ff;
   logic [ROW_W-1:0]  row_ff;
   logic [COL_W-1:0]  colreq_ff;
   logic [CELL_W-1:0] rd_data_ff;
   logic [COL_W-1:0]  rsp_col_ff;
   logic [ROW_W-1:0]  rsp_row_ff;
   logic [CELL_W-1:0] rsp_cell_ff;
   logic              rsp_sc_ff;

   // Screen store, rows kept in a circular order starting at base_ff
   logic [CELL_W-1:0] screen_ff [CELLS];

   logic [ATTR_W-1:0] attr;
   logic [ATTR_W-1:0] fill_attr;
   logic [CHAR_W-1:0] put_char;
   logic              wrap_hit;
   logic              line_last;
   logic              rd_in_range;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [CELL_W-1:0] mem_wdata;
   logic [ADDR_W-1:0] mem_raddr;

   assign attr      = {bg_ff, fg_ff};
   assign fill_attr = cmd.sweep_reset_attr ? RESET_ATTR : attr;
   assign put_char  = (char_ff == CHAR_TAB) ? CHAR_SPACE : char_ff;
   assign wrap_hit  = (char_ff == CHAR_NEWLINE) || (col_ff == COL_W'(COLUMNS - 1));
   assign line_last = (line_ff == ROW_W'(ROWS - 1));
   assign rd_in_range = ({1'b0, row_ff} < (ROW_W+1)'(ROWS)) &&
                        ({1'b0, colreq_ff} < (COL_W+1)'(COLUMNS));

   // Status to the controller
   always_comb begin
      status.op           = op_ff;
      status.char_zero    = (char_ff == CHAR_NULL);
      status.char_newline = (char_ff == CHAR_NEWLINE);
      status.scroll_hit   = wrap_hit && line_last;
      status.more_after   = (tab_left_ff > TAB_W'(1));
      status.chars_left   = (tab_left_ff != '0);
      status.sweep_last   = (sweep_cnt_ff == '0);
      status.rsp_busy     = rsp_valid_ff && !rsp_ready;
   end

   // Cursor, scroll and sweep bookkeeping
   always_comb begin
      col_in        = col_ff;
      line_in       = line_ff;
      base_in       = base_ff;
      sweep_addr_in = sweep_addr_ff;
      sweep_cnt_in  = sweep_cnt_ff;
      tab_left_in   = tab_left_ff;
      sc_in         = sc_ff;
      if (cmd.accept) begin
         sc_in       = 1'b0;
         tab_left_in = (req_char_code == CHAR_TAB) ? TAB_W'(TAB_SPACES) : TAB_W'(1);
      end
      if (cmd.write_char || cmd.newline) begin
         tab_left_in = tab_left_ff - TAB_W'(1);
         if (wrap_hit) begin
            col_in = '0;
            if (line_last) begin
               // scroll: old top row becomes the blank bottom row
               base_in       = (base_ff == ROW_W'(ROWS - 1)) ? '0 : base_ff + ROW_W'(1);
               sweep_addr_in = cell_addr(base_ff, '0);
               sweep_cnt_in  = ADDR_W'(COLUMNS - 1);
               sc_in         = 1'b1;
            end else begin
               line_in = line_ff + ROW_W'(1);
            end
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
      if (cmd.set_col) begin
         col_in = ({1'b0, colreq_ff} >= (COL_W+1)'(COLUMNS)) ? COL_W'(COLUMNS - 1) : colreq_ff;
      end
      if (cmd.set_row) begin
         line_in = ({1'b0, row_ff} >= (ROW_W+1)'(ROWS)) ? ROW_W'(ROWS - 1) : row_ff;
      end
      if (cmd.clear_start) begin
         col_in        = '0;
         line_in       = '0;
         base_in       = '0;
         sweep_addr_in = '0;
         sweep_cnt_in  = ADDR_W'(CELLS - 1);
      end
      if (cmd.sweep_write) begin
         sweep_addr_in = sweep_addr_ff + ADDR_W'(1);
         sweep_cnt_in  = sweep_cnt_ff - ADDR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff        <= '0;
         line_ff       <= '0;
         base_ff       <= '0;
         sweep_addr_ff <= '0;
         sweep_cnt_ff  <= ADDR_W'(CELLS - 1);
         tab_left_ff   <= '0;
         sc_ff         <= 1'b0;
      end else begin
         col_ff        <= col_in;
         line_ff       <= line_in;
         base_ff       <= base_in;
         sweep_addr_ff <= sweep_addr_in;
         sweep_cnt_ff  <= sweep_cnt_in;
         tab_left_ff   <= tab_left_in;
         sc_ff         <= sc_in;
      end
   end

   // Color registers
   always_ff @(posedge clock) begin
      if (reset) begin
         bg_ff <= RESET_BG;
         fg_ff <= RESET_FG;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_BACKGROUND: bg_ff <= csr_wdata;
            CSR_FOREGROUND: fg_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Request capture
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff     <= req_type;
         char_ff   <= req_char_code;
         row_ff    <= req_row;
         colreq_ff <= req_column;
      end
   end

   // Screen store ports
   assign mem_we    = cmd.write_char || cmd.sweep_write;
   assign mem_waddr = cmd.sweep_write ? sweep_addr_ff
                                      : cell_addr(phys_row(line_ff, base_ff), col_ff);
   assign mem_wdata = cmd.sweep_write ? {fill_attr, CHAR_SPACE} : {attr, put_char};
   assign mem_raddr = rd_in_range ? cell_addr(phys_row(row_ff, base_ff), colreq_ff) : '0;

   always_ff @(posedge clock) begin
      if (mem_we) screen_ff[mem_waddr] <= mem_wdata;
   end

   always_ff @(posedge clock) begin
      if (cmd.read_cell) rd_data_ff <= screen_ff[mem_raddr];
   end

   // Result word
   assign rsp_valid_in = cmd.load_rsp || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_col_ff  <= col_ff;
         rsp_row_ff  <= line_ff;
         rsp_cell_ff <= ((op_ff == OP_READ) && rd_in_range) ? rd_data_ff : '0;
         rsp_sc_ff   <= sc_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_cursor_column = rsp_col_ff;
   assign rsp_cursor_row    = rsp_row_ff;
   assign rsp_cell_value    = rsp_cell_ff;
   assign rsp_scrolled      = rsp_sc_ff;

endmodule

### design/text_console_cursor_scroll.sv
// Top level of the text console: controller, datapath and checks.
//
//   channel | direction | handshake            | words
//   req_    | in        | req_valid/req_ready  | type, char_code, row, column
//   rsp_    | out       | rsp_valid/rsp_ready  | cursor_column, cursor_row, cell_value, scrolled
//   csr_    | in        | csr_wr_en            | csr_index, csr_wdata (4-bit colors)
//
// One request at a time. Each scroll adds a fill of the new bottom row through the single
// store write port; a tab is written as four spaces, and a clear blanks every cell.
// After reset a blanking pass over the whole screen runs before the first word is accepted;
// color writes are taken during it. A new request is taken while the last result
// still waits in the output register; a stalled result only holds the next one back.
`include "text_console_cursor_scroll_defines.svh"

module text_console_cursor_scroll import tccs_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [2:0]          req_type,
   input  logic [CHAR_W-1:0]   req_char_code,
   input  logic [ROW_W-1:0]    req_row,
   input  logic [COL_W-1:0]    req_column,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [COL_W-1:0]    rsp_cursor_column,
   output logic [ROW_W-1:0]    rsp_cursor_row,
   output logic [CELL_W-1:0]   rsp_cell_value,
   output logic                rsp_scrolled,
   input  logic                csr_wr_en,
   input  csr_idx_type         csr_index,
   input  logic [COLOR_W-1:0]  csr_wdata
);

   cmd_type    cmd;
   status_type status;

   tccs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   tccs_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_type          (req_type),
      .req_char_code     (req_char_code),
      .req_row           (req_row),
      .req_column        (req_column),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_cursor_column (rsp_cursor_column),
      .rsp_cursor_row    (rsp_cursor_row),
      .rsp_cell_value    (rsp_cell_value),
      .rsp_scrolled      (rsp_scrolled),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   // Checks
   logic [3:0] store_ops;
   logic       rsp_in_bounds;
   logic       rsp_on_bottom;

   assign store_ops     = {cmd.write_char, cmd.newline, cmd.sweep_write, cmd.read_cell};
   assign rsp_in_bounds = ({1'b0, rsp_cursor_column} < (COL_W+1)'(COLUMNS)) &&
                          ({1'b0, rsp_cursor_row} < (ROW_W+1)'(ROWS));
   assign rsp_on_bottom = (rsp_cursor_row == ROW_W'(ROWS - 1));

   `TCCS_ASSERT_NXT(a_one_item_at_a_time, req_valid && req_ready, !req_ready)
   `TCCS_ASSERT_IMP(a_one_store_op, 1'b1, $onehot0(store_ops))
   `TCCS_ASSERT_IMP(a_cursor_in_bounds, rsp_valid, rsp_in_bounds)
   `TCCS_ASSERT_IMP(a_scroll_on_bottom, rsp_valid && rsp_scrolled, rsp_on_bottom)

endmodule
